FILE: design/first_fit_free_list_allocator_unit_assert.svh
// Assertion macros used by the allocator port checker.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define FFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, off while reset is asserted.
`define FFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: design/ffa_pkg.sv
// Types, codes and constants of the first-fit free-list allocator.
package ffa_pkg;

  // Default page geometry
  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned ALIGN_BYTES_DEF = 16;
  // Raw header: one size word and one link word
  localparam int unsigned HDR_RAW         = 16;

  localparam int unsigned FIELD_W  = 13;
  localparam int unsigned STATUS_W = 3;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_FRESH  = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_REUSED = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_NOROOM = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STAT_FREED  = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] STAT_DOUBLE = STATUS_W'(4);

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] user_address;
  } ffa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  address;
  } ffa_out_t;

  // Write enables of the block store fields
  typedef struct packed {
    logic size_we;
    logic use_we;
    logic next_we;
  } ffa_we_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_BUMP,
    S_FREE_CHK,
    S_DONE
  } ffa_state_e;

  // Header bytes rounded up to the alignment (alignment is a power of two)
  function automatic int unsigned hdr_bytes(int unsigned align);
    return (HDR_RAW + align - 1) & ~(align - 1);
  endfunction

  function automatic int unsigned max_of(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: design/ffa_sub.sv
// Shared subtract-and-compare unit: difference and a >= b.
module ffa_sub import ffa_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         ge_o
);

  logic [W:0] full;

  // Subtract with borrow out; no borrow means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[W-1:0];
  assign ge_o   = ~full[W];

endmodule

FILE: design/ffa_store.sv
// Block header store: size, in-use mark and next link per granule.
module ffa_store import ffa_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IW    = 8,
  parameter int unsigned SZW   = 12,
  parameter int unsigned LW    = 9
) (
  input  logic           clk_i,
  input  logic           rd_en_i,
  input  logic [IW-1:0]  rd_addr_i,
  input  ffa_we_t        we_i,
  input  logic [IW-1:0]  wa_addr_i,
  input  logic [IW-1:0]  wb_addr_i,
  input  logic [SZW-1:0] wr_size_i,
  input  logic           wr_use_i,
  input  logic [LW-1:0]  wr_next_i,
  output logic [SZW-1:0] rd_size_o,
  output logic           rd_use_o,
  output logic [LW-1:0]  rd_next_o
);

  logic [SZW-1:0] size_mem [DEPTH];
  logic           use_mem  [DEPTH];
  logic [LW-1:0]  next_mem [DEPTH];

  logic [SZW-1:0] rd_size_q;
  logic           rd_use_q;
  logic [LW-1:0]  rd_next_q;

  // Write size and mark at port A, link at port B
  always_ff @(posedge clk_i) begin
    if (we_i.size_we) size_mem[wa_addr_i] <= wr_size_i;
    if (we_i.use_we)  use_mem[wa_addr_i]  <= wr_use_i;
    if (we_i.next_we) next_mem[wb_addr_i] <= wr_next_i;
  end

  // Registered read of one header
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_size_q <= size_mem[rd_addr_i];
      rd_use_q  <= use_mem[rd_addr_i];
      rd_next_q <= next_mem[rd_addr_i];
    end
  end

  assign rd_size_o = rd_size_q;
  assign rd_use_o  = rd_use_q;
  assign rd_next_o = rd_next_q;

endmodule

FILE: design/first_fit_free_list_allocator_unit.sv
// Top level of the first-fit free-list allocator over one page.
//
// Each input word is an allocate (size in bytes) or a free (user offset), and
// each gives exactly one result word. A free reads its header, checks the
// in-use mark in the check state and then passes its result to the output, or
// goes straight to the output when its offset names no header granule. An
// allocate walks the free list until an entry fits, or walks all listed blocks
// and then falls back to bumping the page end; an empty list goes straight to
// the bump. The walk visits one list entry per cycle, set by the single read
// port of the header store and the one shared subtract-and-compare unit. The
// input is stalled from acceptance until the result is loaded into the output
// register, which then waits for the consumer while the next word may already
// be taken. The header store needs no clearing after reset.
module first_fit_free_list_allocator_unit import ffa_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ffa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ffa_out_t out_data_o
);

  localparam int unsigned BLOCK_COUNT = PAGE_BYTES / ALIGN_BYTES;
  localparam int unsigned IW     = $clog2(BLOCK_COUNT);
  localparam int unsigned LW     = IW + 1;
  localparam int unsigned AL     = $clog2(ALIGN_BYTES);
  localparam int unsigned SZW    = $clog2(PAGE_BYTES);
  localparam int unsigned HDR    = hdr_bytes(ALIGN_BYTES);
  localparam int unsigned NEED_W = FIELD_W + 1;
  localparam int unsigned CW     = max_of(SZW + 1, FIELD_W + 2);

  localparam logic [LW-1:0]     NIL     = LW'(BLOCK_COUNT);
  localparam logic [CW-1:0]     HDR_C   = CW'(HDR);
  localparam logic [CW-1:0]     PAGE_C  = CW'(PAGE_BYTES);
  localparam logic [CW-1:0]     COUNT_C = CW'(BLOCK_COUNT);
  localparam logic [NEED_W-1:0] AMASK   = NEED_W'(ALIGN_BYTES - 1);

  ffa_state_e state_q, state_d;
  logic [LW-1:0]     head_q, head_d;
  logic [CW-1:0]     bump_q, bump_d;
  logic [CW-1:0]     room_q, room_d;
  logic              out_valid_q, out_valid_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [LW-1:0]     prev_q, prev_d;
  logic [LW-1:0]     steps_q, steps_d;
  ffa_out_t          res_q, res_d;
  ffa_out_t          out_q, out_d;

  // Store interface
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  ffa_we_t        we;
  logic [IW-1:0]  wa_addr;
  logic [IW-1:0]  wb_addr;
  logic [SZW-1:0] wr_size;
  logic           wr_use;
  logic [LW-1:0]  wr_next;
  logic [SZW-1:0] rd_size;
  logic           rd_use;
  logic [LW-1:0]  rd_next;

  // Shared unit
  logic [CW-1:0] sub_a, sub_b, sub_diff;
  logic          sub_ge;

  // Request decode
  logic [NEED_W-1:0] need_sum;
  logic [NEED_W-1:0] need_round;
  logic [CW-1:0]     need_hdr;
  logic [CW-1:0]     free_base;
  logic [CW-1:0]     free_idx;
  logic              free_bad;
  logic [LW-1:0]     steps_n;
  logic              next_nil;
  logic [CW-1:0]     reuse_addr;

  ffa_store #(
    .DEPTH (BLOCK_COUNT),
    .IW    (IW),
    .SZW   (SZW),
    .LW    (LW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .we_i      (we),
    .wa_addr_i (wa_addr),
    .wb_addr_i (wb_addr),
    .wr_size_i (wr_size),
    .wr_use_i  (wr_use),
    .wr_next_i (wr_next),
    .rd_size_o (rd_size),
    .rd_use_o  (rd_use),
    .rd_next_o (rd_next)
  );

  ffa_sub #(
    .W (CW)
  ) u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  // Round the request up to the alignment; add the header for bumping
  assign need_sum   = NEED_W'(in_data_i.request_size) + AMASK;
  assign need_round = need_sum & ~AMASK;
  assign need_hdr   = CW'(need_q) + HDR_C;

  // Decode a free offset into a header granule
  assign free_base = CW'(in_data_i.user_address) - HDR_C;
  assign free_idx  = free_base >> AL;
  assign free_bad  = (CW'(in_data_i.user_address) < HDR_C)
                   | (|in_data_i.user_address[AL-1:0])
                   | (free_idx >= COUNT_C);

  // Walk bookkeeping
  assign steps_n    = steps_q + LW'(1);
  assign next_nil   = rd_next >= NIL;
  assign reuse_addr = (CW'(cur_q[IW-1:0]) << AL) + HDR_C;

  // Select the shared unit's operands: fit check or page room check
  always_comb begin
    if (state_q == S_BUMP) begin
      sub_a = room_q;
      sub_b = need_hdr;
    end else begin
      sub_a = CW'(rd_size);
      sub_b = CW'(need_q);
    end
  end

  // Sequence one word through walk, bump or free
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    bump_d      = bump_q;
    room_d      = room_q;
    need_d      = need_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we          = '0;
    wa_addr     = '0;
    wb_addr     = '0;
    wr_size     = '0;
    wr_use      = 1'b0;
    wr_next     = '0;

    // Drop the output word once taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          need_d = need_round;
          if (in_data_i.command == CMD_ALLOC) begin
            if (head_q >= NIL) begin
              state_d = S_BUMP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q[IW-1:0];
              cur_d   = head_q;
              prev_d  = NIL;
              steps_d = '0;
              state_d = S_WALK;
            end
          end else if (free_bad) begin
            res_d   = '{status: STAT_DOUBLE, address: '0};
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = free_idx[IW-1:0];
            cur_d   = {1'b0, free_idx[IW-1:0]};
            state_d = S_FREE_CHK;
          end
        end
      end

      S_WALK: begin
        if (sub_ge) begin
          // Unlink the fitting block and mark it in use
          we.use_we = 1'b1;
          wa_addr   = cur_q[IW-1:0];
          wr_use    = 1'b1;
          if (prev_q >= NIL) begin
            head_d = rd_next;
          end else begin
            we.next_we = 1'b1;
            wb_addr    = prev_q[IW-1:0];
            wr_next    = rd_next;
          end
          res_d   = '{status: STAT_REUSED, address: reuse_addr[FIELD_W-1:0]};
          state_d = S_DONE;
        end else if (next_nil || steps_n >= NIL) begin
          state_d = S_BUMP;
        end else begin
          // Advance to the next list entry
          rd_en   = 1'b1;
          rd_addr = rd_next[IW-1:0];
          prev_d  = cur_q;
          cur_d   = rd_next;
          steps_d = steps_n;
        end
      end

      S_BUMP: begin
        if (sub_ge) begin
          we      = '{size_we: 1'b1, use_we: 1'b1, next_we: 1'b1};
          wa_addr = bump_q[AL +: IW];
          wb_addr = bump_q[AL +: IW];
          wr_size = need_q[SZW-1:0];
          wr_use  = 1'b1;
          wr_next = NIL;
          bump_d  = bump_q + need_hdr;
          room_d  = sub_diff;
          res_d   = '{status: STAT_FRESH, address: FIELD_W'(bump_q + HDR_C)};
        end else begin
          res_d = '{status: STAT_NOROOM, address: '0};
        end
        state_d = S_DONE;
      end

      S_FREE_CHK: begin
        if (!rd_use) begin
          res_d = '{status: STAT_DOUBLE, address: '0};
        end else begin
          // Clear the mark and push the block at the head
          we.use_we  = 1'b1;
          we.next_we = 1'b1;
          wa_addr    = cur_q[IW-1:0];
          wb_addr    = cur_q[IW-1:0];
          wr_use     = 1'b0;
          wr_next    = head_q;
          head_d     = cur_q;
          res_d      = '{status: STAT_FREED, address: '0};
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL;
      bump_q      <= '0;
      room_q      <= PAGE_C;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      bump_q      <= bump_d;
      room_q      <= room_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    need_q  <= need_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    steps_q <= steps_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/ffa_checker.sv
// Port checker of the allocator and its bind to the top level.
`include "first_fit_free_list_allocator_unit_assert.svh"

module ffa_checker import ffa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input ffa_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ffa_out_t out_data_o
);

  // Hold a stalled result word
  `FFA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `FFA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // Busy in the cycle after a word is taken
  `FFA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // No address on failures and frees
  `FFA_ASSERT_IMP(a_zero_address, clk_i, rst_ni,
    out_valid_o && (out_data_o.status == STAT_NOROOM || out_data_o.status == STAT_FREED
    || out_data_o.status == STAT_DOUBLE), out_data_o.address == '0)

endmodule

bind first_fit_free_list_allocator_unit ffa_checker u_ffa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: test/first_fit_free_list_allocator_checker.sv
// Checker for the allocator: watches both channels, predicts each result word and compares.
module first_fit_free_list_allocator_checker import ffa_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  ffa_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  ffa_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRANULES = PAGE_BYTES / ALIGN_BYTES;
  localparam int unsigned LINK_W   = $clog2(GRANULES) + 1;
  localparam int unsigned NO_LINK  = GRANULES;
  // Header span: size word plus link word, padded to a whole granule
  localparam int unsigned HDR_SPAN = (HDR_RAW + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;

  // Shadow allocator state, indexed by header granule
  int unsigned        page_top;
  int unsigned        free_head;
  logic [FIELD_W-1:0] blk_size [GRANULES];
  logic               blk_busy [GRANULES];
  logic [LINK_W-1:0]  blk_link [GRANULES];

  ffa_out_t awaited_results [$];
  ffa_out_t oldest;
  int       mismatch_count;

  // Apply one command word to the shadow state and return the result word it yields
  function automatic ffa_out_t allocator_outcome(input ffa_in_t w);
    ffa_out_t    r;
    int unsigned need;
    int unsigned prev;
    int unsigned cur;
    int unsigned steps;
    int unsigned base;
    int unsigned idx;
    bit          hit;
    r.status  = STAT_DOUBLE;
    r.address = '0;
    if (w.command == CMD_ALLOC) begin
      need  = (32'(w.request_size) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
      prev  = NO_LINK;
      cur   = free_head;
      steps = 0;
      hit   = 1'b0;
      // First fit over the free list, newest block first
      while (!hit && cur < GRANULES && steps < GRANULES) begin
        if (blk_size[cur] >= need) begin
          hit = 1'b1;
        end else begin
          prev = cur;
          cur  = blk_link[cur];
          steps++;
        end
      end
      if (hit) begin
        if (prev == NO_LINK) begin
          free_head = blk_link[cur];
        end else begin
          blk_link[prev] = blk_link[cur];
        end
        blk_busy[cur] = 1'b1;
        r.status  = STAT_REUSED;
        r.address = FIELD_W'(cur * ALIGN_BYTES + HDR_SPAN);
      end else if (page_top + HDR_SPAN + need > PAGE_BYTES) begin
        r.status = STAT_NOROOM;
      end else begin
        // Carve a fresh block at the page top
        idx           = page_top / ALIGN_BYTES;
        blk_size[idx] = FIELD_W'(need);
        blk_busy[idx] = 1'b1;
        blk_link[idx] = LINK_W'(NO_LINK);
        page_top      = page_top + HDR_SPAN + need;
        r.status      = STAT_FRESH;
        r.address     = FIELD_W'(idx * ALIGN_BYTES + HDR_SPAN);
      end
    end else if (32'(w.user_address) >= HDR_SPAN) begin
      base = 32'(w.user_address) - HDR_SPAN;
      idx  = base / ALIGN_BYTES;
      // Only an in-use header on a granule inside the page is released
      if (base % ALIGN_BYTES == 0 && idx < GRANULES && blk_busy[idx]) begin
        blk_busy[idx] = 1'b0;
        blk_link[idx] = LINK_W'(free_head);
        free_head     = idx;
        r.status      = STAT_FREED;
      end
    end
    return r;
  endfunction

  // Compare accepted result words first: none can belong to a word taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_top  = 0;
      free_head = NO_LINK;
      for (int g = 0; g < GRANULES; g++) begin
        blk_size[g] = '0;
        blk_busy[g] = 1'b0;
        blk_link[g] = '0;
      end
      awaited_results.delete();
      mismatch_count = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result word with none awaited: status %0d address %0d",
                 out_data_i.status, out_data_i.address);
          mismatch_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data_i.status !== oldest.status) begin
            $error("status mismatch: expected %0d, got %0d", oldest.status, out_data_i.status);
            mismatch_count++;
          end
          if (out_data_i.address !== oldest.address) begin
            $error("address mismatch: expected %0d, got %0d",
                   oldest.address, out_data_i.address);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(allocator_outcome(in_data_i));
      end
      fail_count_o <= mismatch_count;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

FILE: test/tb_first_fit_free_list_allocator_unit.sv
// Testbench top for the allocator: clock, reset, command stimulus, result stalls and verdict.
module tb_first_fit_free_list_allocator_unit import ffa_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS   = 1950;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned HDR_SPAN       = 16;
  localparam int unsigned PAGE_SPAN      = PAGE_BYTES_DEF;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ffa_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ffa_out_t out_data;
  int       fail_count;
  int       pending;

  // Addresses handed out so far, each kept once, in order of arrival
  logic [FIELD_W-1:0] handed_out [$];
  bit                 pooled [int];
  int                 burst_left;
  int                 idle_cycles = 0;

  first_fit_free_list_allocator_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  first_fit_free_list_allocator_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Collect returned addresses at the falling edge ahead of the edge that takes them
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall &&
        (out_data.status == STAT_FRESH || out_data.status == STAT_REUSED) &&
        !pooled.exists(int'(out_data.address))) begin
      pooled[int'(out_data.address)] = 1'b1;
      handed_out.push_back(out_data.address);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one word in bursts with random gaps; return at the edge that accepts it
  task automatic send_word(input ffa_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Unused field of each command carries random bits
  task automatic send_alloc(input int unsigned size);
    ffa_in_t w;
    w.command      = CMD_ALLOC;
    w.request_size = FIELD_W'(size);
    w.user_address = FIELD_W'($urandom());
    send_word(w);
  endtask

  task automatic send_free(input int unsigned addr);
    ffa_in_t w;
    w.command      = CMD_FREE;
    w.request_size = FIELD_W'($urandom());
    w.user_address = FIELD_W'(addr);
    send_word(w);
  endtask

  // Hold the input idle until enough addresses have come back
  task automatic hold_until_handed(input int count);
    in_valid <= 1'b0;
    do @(posedge clk); while (handed_out.size() < count);
  endtask

  // Free address that no store entry can match
  function automatic int unsigned stray_address();
    int unsigned pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      return $urandom_range(0, HDR_SPAN - 1);
    end else if (pick == 1) begin
      return 32'({9'($urandom_range(0, 511)), 4'($urandom_range(1, 15))});
    end
    return HDR_SPAN + 16 * $urandom_range(PAGE_SPAN / 16, 510);
  endfunction

  // Mostly small allocates and frees of returned blocks, some oversize and stray words
  task automatic send_random_word(output bit counted);
    int unsigned pick;
    int unsigned size;
    int unsigned slot;
    counted = 1'b1;
    pick    = $urandom_range(0, 99);
    if (pick < 55 || handed_out.size() == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        size = 0;
      end else if (pick < 60) begin
        size = $urandom_range(1, 48);
      end else if (pick < 85) begin
        size = $urandom_range(49, 256);
      end else if (pick < 95) begin
        size = $urandom_range(257, PAGE_SPAN);
      end else begin
        size = $urandom_range(PAGE_SPAN + 1, 8191);
      end
      send_alloc(size);
    end else if (pick < 61) begin
      counted = 1'b0;
      send_free(stray_address());
    end else begin
      // Favor recent blocks so frees and reuses interleave tightly
      if ($urandom_range(0, 99) < 60 && handed_out.size() > 8) begin
        slot = $urandom_range(handed_out.size() - 8, handed_out.size() - 1);
      end else begin
        slot = $urandom_range(0, handed_out.size() - 1);
      end
      send_free(32'(handed_out[slot]));
    end
  endtask

  // Receiver: segments of free flow, light and heavy random stalls, periodic
  // patterns, and now and then a long hold-off
  initial begin
    int seg;
    int mode;
    int len;
    int period;
    out_stall = 1'b0;
    seg = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      seg++;
      if (seg % 40 == 6) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode   = $urandom_range(0, 3);
        len    = $urandom_range(10, 120);
        period = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= ($urandom_range(0, 99) < 30);
            end
            2: begin
              out_stall <= ($urandom_range(0, 99) < 75);
            end
            default: begin
              out_stall <= ((i / period) % 2) == 1;
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Sender: reset, directed words, random words, drain, verdict
  initial begin
    int unsigned sent;
    bit          counted;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero size, rounding at and past one granule, all-ones and page-size requests
    send_alloc(0);
    send_alloc(1);
    send_alloc(16);
    send_alloc(17);
    send_alloc(8191);
    send_alloc(PAGE_SPAN);
    // Frees below the header, off a granule, past the page, all ones
    send_free(0);
    send_free(HDR_SPAN - 1);
    send_free(33);
    send_free(HDR_SPAN + PAGE_SPAN);
    send_free(8191);
    hold_until_handed(4);
    // Free, then double free, then reuse through the list head
    send_free(32'(handed_out[1]));
    send_free(32'(handed_out[1]));
    send_free(32'(handed_out[3]));
    send_alloc(20);
    send_alloc(0);
    send_alloc(16);
    // Walk past two blocks too small, fall back to the page top, then reuse the head
    send_free(32'(handed_out[0]));
    send_free(32'(handed_out[2]));
    send_alloc(32);
    send_alloc(16);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      send_random_word(counted);
      if (counted) begin
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every awaited result, then let any stray one show up
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
